@@ rtl/uartq_pkg.sv @@
// shared constants and codes for the uart queue engine
package uartq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  localparam int unsigned FuncW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 11;
  localparam int unsigned FillW  = 5;

  // operation codes
  localparam logic [FuncW-1:0] FUNC_PUSH_TX  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_POP_RX   = 3'd1;
  localparam logic [FuncW-1:0] FUNC_TX_EMPTY = 3'd2;
  localparam logic [FuncW-1:0] FUNC_RX_BYTE  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_START    = 3'd4;
  localparam logic [FuncW-1:0] FUNC_CLEAR    = 3'd5;

  localparam logic [CntW-1:0] CNT_FULL = CntW'(QueueDepth);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(QueueDepth - 1);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PtrW'(1);
  endfunction

endpackage

@@ rtl/uartq_if.sv @@
// handshake channels: operation words in, result words out
interface uartq_req_if;
  logic                         valid;
  logic                         ready;
  logic [uartq_pkg::FuncW-1:0]  func;
  logic [uartq_pkg::ByteW-1:0]  byte_in;
  logic                         parity_err;
  logic                         frame_err;
  logic                         overrun_err;

  modport source (output valid, func, byte_in, parity_err, frame_err, overrun_err,
                  input ready);
  modport sink   (input valid, func, byte_in, parity_err, frame_err, overrun_err,
                  output ready);
endinterface

interface uartq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         send_valid;
  logic [uartq_pkg::ByteW-1:0]  send_byte;
  logic                         send_done;
  logic                         got_valid;
  logic [uartq_pkg::WordW-1:0]  got_word;
  logic                         tx_overflowed;
  logic                         rx_overflowed;
  logic [uartq_pkg::FillW-1:0]  tx_fill;
  logic [uartq_pkg::FillW-1:0]  rx_fill;

  modport source (output valid, send_valid, send_byte, send_done, got_valid, got_word,
                  tx_overflowed, rx_overflowed, tx_fill, rx_fill,
                  input ready);
  modport sink   (input valid, send_valid, send_byte, send_done, got_valid, got_word,
                  tx_overflowed, rx_overflowed, tx_fill, rx_fill,
                  output ready);
endinterface

@@ rtl/uart_tx_rx_queue_engine_core.sv @@
// buffered uart queue pair: transmit byte queue, receive word queue, status
//
// channel   | dir | word carried
// ----------+-----+--------------------------------------------------------
// req_i     | in  | func, byte_in, parity_err, frame_err, overrun_err
// rsp_o     | out | send/got words, done flag, overflow flags, fill levels
//
// one word per cycle sustained while the result channel is not stalled; input
// register, then queue update into the result register
// the queue update for a word is one pointer/count step on flop arrays
// async active-low reset empties both queues and clears the busy and overflow flags
// a stalled result holds the update stage; the input register still takes a
// word while the update stage is free, so the pipeline fills before stalling
module uart_tx_rx_queue_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  uartq_req_if.sink          req_i,
  uartq_rsp_if.source        rsp_o
);

  localparam int unsigned PtrW  = uartq_pkg::PtrW;
  localparam int unsigned CntW  = uartq_pkg::CntW;
  localparam int unsigned ByteW = uartq_pkg::ByteW;
  localparam int unsigned WordW = uartq_pkg::WordW;
  localparam int unsigned FillW = uartq_pkg::FillW;

  // input register
  logic                           in_vld_q;
  logic [uartq_pkg::FuncW-1:0]    func_q;
  logic [ByteW-1:0]               byte_q;
  logic                           perr_q, ferr_q, oerr_q;

  // queue state
  logic [ByteW-1:0] tx_mem [uartq_pkg::QueueDepth];
  logic [WordW-1:0] rx_mem [uartq_pkg::QueueDepth];
  logic [PtrW-1:0]  tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [PtrW-1:0]  rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [CntW-1:0]  tx_cnt_q, tx_cnt_d, rx_cnt_q, rx_cnt_d;
  logic             sending_q, sending_d;
  logic             tx_ovf_q, tx_ovf_d, rx_ovf_q, rx_ovf_d;

  // result register
  logic             out_vld_q;
  logic             send_valid_q, send_valid_d;
  logic [ByteW-1:0] send_byte_q, send_byte_d;
  logic             send_done_q, send_done_d;
  logic             got_valid_q, got_valid_d;
  logic [WordW-1:0] got_word_q, got_word_d;

  logic             tx_wr, rx_wr;
  logic [WordW-1:0] rx_wr_word;
  logic [2:0]       errs;
  logic             step;

  // update stage fires when the result slot is free or being drained
  assign step        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      func_q <= req_i.func;
      byte_q <= req_i.byte_in;
      perr_q <= req_i.parity_err;
      ferr_q <= req_i.frame_err;
      oerr_q <= req_i.overrun_err;
    end
  end

  // error bits replace the data byte when any is set
  assign errs       = {oerr_q, ferr_q, perr_q};
  assign rx_wr_word = (errs != 3'b000) ? {errs, {ByteW{1'b0}}} : {3'b000, byte_q};

  always_comb begin
    tx_head_d    = tx_head_q;
    tx_tail_d    = tx_tail_q;
    tx_cnt_d     = tx_cnt_q;
    rx_head_d    = rx_head_q;
    rx_tail_d    = rx_tail_q;
    rx_cnt_d     = rx_cnt_q;
    sending_d    = sending_q;
    tx_ovf_d     = tx_ovf_q;
    rx_ovf_d     = rx_ovf_q;
    send_valid_d = 1'b0;
    send_byte_d  = '0;
    send_done_d  = 1'b0;
    got_valid_d  = 1'b0;
    got_word_d   = '0;
    tx_wr        = 1'b0;
    rx_wr        = 1'b0;
    unique case (func_q)
      uartq_pkg::FUNC_PUSH_TX: begin
        if (tx_cnt_q < uartq_pkg::CNT_FULL) begin
          tx_wr     = 1'b1;
          tx_tail_d = uartq_pkg::ptr_next(tx_tail_q);
          tx_cnt_d  = tx_cnt_q + CntW'(1);
        end else begin
          tx_ovf_d = 1'b1;
        end
      end
      uartq_pkg::FUNC_POP_RX: begin
        if (rx_cnt_q != '0) begin
          got_valid_d = 1'b1;
          got_word_d  = rx_mem[rx_head_q];
          rx_head_d   = uartq_pkg::ptr_next(rx_head_q);
          rx_cnt_d    = rx_cnt_q - CntW'(1);
        end
      end
      uartq_pkg::FUNC_TX_EMPTY: begin
        if (tx_cnt_q != '0) begin
          send_valid_d = 1'b1;
          send_byte_d  = tx_mem[tx_head_q];
          tx_head_d    = uartq_pkg::ptr_next(tx_head_q);
          tx_cnt_d     = tx_cnt_q - CntW'(1);
          sending_d    = 1'b1;
        end else begin
          // queue drained: transmission over
          sending_d   = 1'b0;
          send_done_d = 1'b1;
        end
      end
      uartq_pkg::FUNC_RX_BYTE: begin
        if (rx_cnt_q < uartq_pkg::CNT_FULL) begin
          rx_wr     = 1'b1;
          rx_tail_d = uartq_pkg::ptr_next(rx_tail_q);
          rx_cnt_d  = rx_cnt_q + CntW'(1);
        end else begin
          rx_ovf_d = 1'b1;
        end
      end
      uartq_pkg::FUNC_START: begin
        // kick-start only when idle with bytes waiting
        if (tx_cnt_q != '0 && !sending_q) begin
          send_valid_d = 1'b1;
          send_byte_d  = tx_mem[tx_head_q];
          tx_head_d    = uartq_pkg::ptr_next(tx_head_q);
          tx_cnt_d     = tx_cnt_q - CntW'(1);
          sending_d    = 1'b1;
        end
      end
      uartq_pkg::FUNC_CLEAR: begin
        // overflow flags are sticky across a clear
        tx_head_d = '0;
        tx_tail_d = '0;
        tx_cnt_d  = '0;
        rx_head_d = '0;
        rx_tail_d = '0;
        rx_cnt_d  = '0;
        sending_d = 1'b0;
      end
      default: begin
        // unused codes only report status
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q <= '0;
      tx_tail_q <= '0;
      tx_cnt_q  <= '0;
      rx_head_q <= '0;
      rx_tail_q <= '0;
      rx_cnt_q  <= '0;
      sending_q <= 1'b0;
      tx_ovf_q  <= 1'b0;
      rx_ovf_q  <= 1'b0;
    end else if (step) begin
      tx_head_q <= tx_head_d;
      tx_tail_q <= tx_tail_d;
      tx_cnt_q  <= tx_cnt_d;
      rx_head_q <= rx_head_d;
      rx_tail_q <= rx_tail_d;
      rx_cnt_q  <= rx_cnt_d;
      sending_q <= sending_d;
      tx_ovf_q  <= tx_ovf_d;
      rx_ovf_q  <= rx_ovf_d;
    end
  end

  // queue storage, no reset: reads are guarded by the counts
  always_ff @(posedge clk_i) begin
    if (step && tx_wr) begin
      tx_mem[tx_tail_q] <= byte_q;
    end
    if (step && rx_wr) begin
      rx_mem[rx_tail_q] <= rx_wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      send_valid_q <= send_valid_d;
      send_byte_q  <= send_byte_d;
      send_done_q  <= send_done_d;
      got_valid_q  <= got_valid_d;
      got_word_q   <= got_word_d;
    end
  end

  // status fields come straight from the state registers, updated with the result
  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.send_valid    = send_valid_q;
  assign rsp_o.send_byte     = send_byte_q;
  assign rsp_o.send_done     = send_done_q;
  assign rsp_o.got_valid     = got_valid_q;
  assign rsp_o.got_word      = got_word_q;
  assign rsp_o.tx_overflowed = tx_ovf_q;
  assign rsp_o.rx_overflowed = rx_ovf_q;
  assign rsp_o.tx_fill       = FillW'(tx_cnt_q);
  assign rsp_o.rx_fill       = FillW'(rx_cnt_q);

`ifndef SYNTHESIS
  a_tx_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_cnt_q <= uartq_pkg::CNT_FULL) else $error("tx count past depth");

  a_rx_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_cnt_q == '0 || rx_cnt_q == uartq_pkg::CNT_FULL) |-> rx_head_q == rx_tail_q)
    else $error("rx pointers disagree with count");

  a_tx_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_cnt_q == '0 || tx_cnt_q == uartq_pkg::CNT_FULL) |-> tx_head_q == tx_tail_q)
    else $error("tx pointers disagree with count");

  a_send_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && send_valid_d) |=> sending_q) else $error("send without busy flag");

  a_done_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(send_done_q && send_valid_q) && !(got_valid_q && send_valid_q))
    else $error("conflicting result flags");
`endif

endmodule

@@ tb/tb_uart_tx_rx_queue_engine_core.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the uart queue engine core
module tb_uart_tx_rx_queue_engine_core;

  localparam int unsigned QueueDepth = uartq_pkg::QueueDepth;
  localparam int unsigned PtrW       = uartq_pkg::PtrW;
  localparam int unsigned CntW       = uartq_pkg::CntW;
  localparam int unsigned FuncW      = uartq_pkg::FuncW;
  localparam int unsigned ByteW      = uartq_pkg::ByteW;
  localparam int unsigned WordW      = uartq_pkg::WordW;
  localparam int unsigned FillW      = uartq_pkg::FillW;

  // select values the block has no operation for
  localparam logic [FuncW-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [FuncW-1:0] FUNC_SPARE7 = 3'd7;

  localparam int RandomWords = 1900;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 8;
  localparam int NumDirected = 25;

  // one request word
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] byte_in;
    logic             parity_err;
    logic             frame_err;
    logic             overrun_err;
  } uart_op_t;

  // one result word, fields in channel order
  typedef struct packed {
    logic             send_valid;
    logic [ByteW-1:0] send_byte;
    logic             send_done;
    logic             got_valid;
    logic [WordW-1:0] got_word;
    logic             tx_overflowed;
    logic             rx_overflowed;
    logic [FillW-1:0] tx_fill;
    logic [FillW-1:0] rx_fill;
  } uart_result_t;

  // directed table row: word to send, and a typed-in result where one is given
  typedef struct packed {
    uart_op_t     op;
    logic         has_exp;
    uart_result_t exp;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  uartq_req_if req_ch ();
  uartq_rsp_if rsp_ch ();

  uart_tx_rx_queue_engine_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // queue pair model: its own copy of both queues, the busy flag and the flags
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] xmit_mem [QueueDepth];
  logic [WordW-1:0] recv_mem [QueueDepth];
  logic [PtrW-1:0]  xmit_rd, xmit_wr, recv_rd, recv_wr;
  logic [CntW-1:0]  xmit_cnt, recv_cnt;
  logic             xmit_busy, xmit_ovf, recv_ovf;

  // results still owed by the block, oldest first
  uart_result_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int work_items    = 0;

  // result checking tallies
  int bad_words     = 0;
  int results_seen  = 0;
  int sends_seen    = 0;
  int pops_seen     = 0;
  int done_seen     = 0;
  bit tx_ovf_seen   = 1'b0;
  bit rx_ovf_seen   = 1'b0;

  // advance the model by one word and return the result it owes
  function automatic uart_result_t predict_step(input uart_op_t op);
    uart_result_t     r;
    logic [WordW-1:0] rx_word;
    r = '0;
    case (op.func)
      uartq_pkg::FUNC_PUSH_TX: begin
        if (xmit_cnt < QueueDepth) begin
          xmit_mem[xmit_wr] = op.byte_in;
          xmit_wr  = xmit_wr + 1'b1;   // depth is a power of two, pointers wrap
          xmit_cnt = xmit_cnt + 1'b1;
        end else begin
          xmit_ovf = 1'b1;
        end
      end
      uartq_pkg::FUNC_POP_RX: begin
        if (recv_cnt != 0) begin
          r.got_valid = 1'b1;
          r.got_word  = recv_mem[recv_rd];
          recv_rd  = recv_rd + 1'b1;
          recv_cnt = recv_cnt - 1'b1;
        end
      end
      uartq_pkg::FUNC_TX_EMPTY: begin
        // a queued byte goes out even when the busy flag was clear
        if (xmit_cnt != 0) begin
          r.send_valid = 1'b1;
          r.send_byte  = xmit_mem[xmit_rd];
          xmit_rd   = xmit_rd + 1'b1;
          xmit_cnt  = xmit_cnt - 1'b1;
          xmit_busy = 1'b1;
        end else begin
          xmit_busy   = 1'b0;
          r.send_done = 1'b1;
        end
      end
      uartq_pkg::FUNC_RX_BYTE: begin
        // any error bit replaces the data byte with zero
        rx_word = {op.overrun_err, op.frame_err, op.parity_err, {ByteW{1'b0}}};
        if (rx_word == '0) rx_word = {3'b000, op.byte_in};
        if (recv_cnt < QueueDepth) begin
          recv_mem[recv_wr] = rx_word;
          recv_wr  = recv_wr + 1'b1;
          recv_cnt = recv_cnt + 1'b1;
        end else begin
          recv_ovf = 1'b1;
        end
      end
      uartq_pkg::FUNC_START: begin
        if (xmit_cnt != 0 && !xmit_busy) begin
          r.send_valid = 1'b1;
          r.send_byte  = xmit_mem[xmit_rd];
          xmit_rd   = xmit_rd + 1'b1;
          xmit_cnt  = xmit_cnt - 1'b1;
          xmit_busy = 1'b1;
        end
      end
      uartq_pkg::FUNC_CLEAR: begin
        // overflow flags survive a clear
        xmit_rd = '0; xmit_wr = '0; xmit_cnt = '0;
        recv_rd = '0; recv_wr = '0; recv_cnt = '0;
        xmit_busy = 1'b0;
      end
      default: ;
    endcase
    r.tx_overflowed = xmit_ovf;
    r.rx_overflowed = recv_ovf;
    r.tx_fill       = FillW'(xmit_cnt);
    r.rx_fill       = FillW'(recv_cnt);
    return r;
  endfunction

  function automatic uart_op_t make_op(input logic [FuncW-1:0] f, input logic [ByteW-1:0] b,
                                       input logic [2:0] errs);
    uart_op_t o;
    o.func        = f;
    o.byte_in     = b;
    o.overrun_err = errs[2];
    o.frame_err   = errs[1];
    o.parity_err  = errs[0];
    return o;
  endfunction

  // typed-in result for the directed part, overflow flags still clear there
  function automatic uart_result_t exp_res(input int sv, input logic [ByteW-1:0] sb,
                                           input int sd, input int gv,
                                           input logic [WordW-1:0] gw,
                                           input int txf, input int rxf);
    uart_result_t r;
    r = '0;
    r.send_valid = 1'(sv);
    r.send_byte  = sb;
    r.send_done  = 1'(sd);
    r.got_valid  = 1'(gv);
    r.got_word   = gw;
    r.tx_fill    = FillW'(txf);
    r.rx_fill    = FillW'(rxf);
    return r;
  endfunction

  function automatic stim_row_t row(input logic [FuncW-1:0] f, input logic [ByteW-1:0] b,
                                    input logic [2:0] errs, input logic chk,
                                    input uart_result_t e);
    stim_row_t s;
    s.op      = make_op(f, b, errs);
    s.has_exp = chk;
    s.exp     = e;
    return s;
  endfunction

  // receive status: mostly clean bytes, some with random error bits
  function automatic logic [2:0] rand_errs();
    return ($urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 7)) : 3'b000;
  endfunction

  function automatic string fmt_result(input uart_result_t r);
    return $sformatf("send=%b/%h done=%b got=%b/%h ovf=%b%b fill=%0d/%0d",
                     r.send_valid, r.send_byte, r.send_done, r.got_valid, r.got_word,
                     r.tx_overflowed, r.rx_overflowed, r.tx_fill, r.rx_fill);
  endfunction

  // ---------------------------------------------------------------------------
  // sender: present one word, idling at random first, predict on acceptance
  // ---------------------------------------------------------------------------
  task automatic drive_item(input uart_op_t op, input bit typed = 1'b0,
                            input uart_result_t typed_res = '0);
    uart_result_t model_res;
    uart_result_t owed;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= op.func;
    req_ch.byte_in     <= op.byte_in;
    req_ch.parity_err  <= op.parity_err;
    req_ch.frame_err   <= op.frame_err;
    req_ch.overrun_err <= op.overrun_err;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    // accepted at this edge; the model still runs on typed rows to keep state
    model_res = predict_step(op);
    owed      = typed ? typed_res : model_res;
    pending_results.insert(pending_results.size(), owed);
    if (op.func <= uartq_pkg::FUNC_CLEAR) work_items++;
  endtask

  // hold the request channel quiet until every owed result is back
  task automatic wait_results_drained();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // random traffic, mostly well-formed bursts so the queues run full and empty
  task automatic run_random(input int budget);
    int target;
    int k;
    target = work_items + budget;
    while (work_items < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // transmit burst, sometimes past full, then drain to the done event
          k = $urandom_range(1, QueueDepth + 4);
          repeat (k)
            drive_item(make_op(uartq_pkg::FUNC_PUSH_TX, ByteW'($urandom), 3'($urandom)));
          if ($urandom_range(0, 1) == 1)
            drive_item(make_op(uartq_pkg::FUNC_START, ByteW'($urandom), 3'($urandom)));
          while (xmit_cnt != 0)
            drive_item(make_op(uartq_pkg::FUNC_TX_EMPTY, ByteW'($urandom), 3'($urandom)));
          drive_item(make_op(uartq_pkg::FUNC_TX_EMPTY, ByteW'($urandom), 3'($urandom)));
        end
        3, 4, 5: begin
          // receive burst, then some pops, occasionally past empty
          k = $urandom_range(1, QueueDepth + 4);
          repeat (k)
            drive_item(make_op(uartq_pkg::FUNC_RX_BYTE, ByteW'($urandom), rand_errs()));
          k = $urandom_range(0, recv_cnt + 2);
          repeat (k)
            drive_item(make_op(uartq_pkg::FUNC_POP_RX, ByteW'($urandom), 3'($urandom)));
        end
        6, 7, 8: begin
          // both queues interleaved
          repeat ($urandom_range(4, 16))
            drive_item(make_op(FuncW'($urandom_range(uartq_pkg::FUNC_PUSH_TX,
                                                     uartq_pkg::FUNC_START)),
                               ByteW'($urandom), rand_errs()));
        end
        default: begin
          // noise: any select value including clear and the unused ones
          repeat ($urandom_range(1, 6))
            drive_item(make_op(FuncW'($urandom_range(uartq_pkg::FUNC_PUSH_TX, FUNC_SPARE7)),
                               ByteW'($urandom), 3'($urandom)));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [NumDirected];

  initial begin
    req_ch.valid       = 1'b0;
    req_ch.func        = uartq_pkg::FUNC_PUSH_TX;
    req_ch.byte_in     = '0;
    req_ch.parity_err  = 1'b0;
    req_ch.frame_err   = 1'b0;
    req_ch.overrun_err = 1'b0;

    xmit_rd = '0; xmit_wr = '0; xmit_cnt = '0;
    recv_rd = '0; recv_wr = '0; recv_cnt = '0;
    xmit_busy = 1'b0; xmit_ovf = 1'b0; recv_ovf = 1'b0;

    //        func                     byte   errs    chk   typed result
    dir_tab = '{
      // empty queues straight after reset
      row(uartq_pkg::FUNC_POP_RX,   8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 0)),
      row(uartq_pkg::FUNC_TX_EMPTY, 8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 1, 0, 11'h000, 0, 0)),
      row(uartq_pkg::FUNC_START,    8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 0)),
      // unused select values only report status
      row(FUNC_SPARE6,              8'hff, 3'b111, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 0)),
      row(FUNC_SPARE7,              8'haa, 3'b101, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 0)),
      // byte extremes through the transmit side
      row(uartq_pkg::FUNC_PUSH_TX,  8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 1, 0)),
      row(uartq_pkg::FUNC_PUSH_TX,  8'hff, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 2, 0)),
      row(uartq_pkg::FUNC_START,    8'h00, 3'b000, 1'b1,
          exp_res(1, 8'h00, 0, 0, 11'h000, 1, 0)),
      // start while already sending does nothing
      row(uartq_pkg::FUNC_START,    8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 1, 0)),
      row(uartq_pkg::FUNC_TX_EMPTY, 8'h00, 3'b000, 1'b1,
          exp_res(1, 8'hff, 0, 0, 11'h000, 0, 0)),
      row(uartq_pkg::FUNC_TX_EMPTY, 8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 1, 0, 11'h000, 0, 0)),
      // receive side: clean byte, each error bit alone, all three together
      row(uartq_pkg::FUNC_RX_BYTE,  8'hff, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 1)),
      row(uartq_pkg::FUNC_RX_BYTE,  8'ha5, 3'b001, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 2)),
      row(uartq_pkg::FUNC_RX_BYTE,  8'h5a, 3'b010, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 3)),
      row(uartq_pkg::FUNC_RX_BYTE,  8'h3c, 3'b100, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 4)),
      row(uartq_pkg::FUNC_RX_BYTE,  8'hff, 3'b111, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 5)),
      row(uartq_pkg::FUNC_POP_RX,   8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 1, 11'h0ff, 0, 4)),
      row(uartq_pkg::FUNC_POP_RX,   8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 1, 11'h100, 0, 3)),
      row(uartq_pkg::FUNC_PUSH_TX,  8'h81, 3'b000, 1'b0, '0),
      // clear drops both queues and the busy flag
      row(uartq_pkg::FUNC_CLEAR,    8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 0)),
      row(uartq_pkg::FUNC_PUSH_TX,  8'h42, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 1, 0)),
      // transmitter-empty sends a queued byte even while idle
      row(uartq_pkg::FUNC_TX_EMPTY, 8'h00, 3'b000, 1'b1,
          exp_res(1, 8'h42, 0, 0, 11'h000, 0, 0)),
      row(uartq_pkg::FUNC_POP_RX,   8'h00, 3'b000, 1'b1,
          exp_res(0, 8'h00, 0, 0, 11'h000, 0, 0)),
      row(uartq_pkg::FUNC_RX_BYTE,  8'h00, 3'b000, 1'b0, '0),
      row(uartq_pkg::FUNC_POP_RX,   8'h00, 3'b000, 1'b0, '0)
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles often, receiver stalls more
    send_idle_pct = 38;
    recv_idle_pct = 54;
    foreach (dir_tab[i]) drive_item(dir_tab[i].op, dir_tab[i].has_exp, dir_tab[i].exp);
    run_random(RandomWords / 3);
    wait_results_drained();

    // roles swapped
    send_idle_pct = 54;
    recv_idle_pct = 38;
    run_random(RandomWords / 3);
    wait_results_drained();

    // back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RandomWords - 2 * (RandomWords / 3));
    wait_results_drained();

    // let any stray result show up before judging
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d words, %0d results: %0d bytes sent, %0d words popped, %0d done events",
             work_items, results_seen, sends_seen, pops_seen, done_seen);
    $display("transmit overflow seen %0b, receive overflow seen %0b, %0d bad results",
             tx_ovf_seen, rx_ovf_seen, bad_words);
    if (bad_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, and every accepted result checked in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    uart_result_t seen;
    uart_result_t want;
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      seen = '{rsp_ch.send_valid, rsp_ch.send_byte, rsp_ch.send_done, rsp_ch.got_valid,
               rsp_ch.got_word, rsp_ch.tx_overflowed, rsp_ch.rx_overflowed,
               rsp_ch.tx_fill, rsp_ch.rx_fill};
      results_seen++;
      if (pending_results.size() == 0) begin
        // nothing owed: the block produced a word out of thin air
        if (bad_words < ReportLimit)
          $display("unexpected result at %0t: %s", $realtime, fmt_result(seen));
        bad_words++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (seen !== want) begin
          if (bad_words < ReportLimit)
            $display("result %0d mismatch at %0t\n  expected %s\n  actual   %s",
                     results_seen, $realtime, fmt_result(want), fmt_result(seen));
          bad_words++;
        end
        if (want.send_valid)    sends_seen++;
        if (want.got_valid)     pops_seen++;
        if (want.send_done)     done_seen++;
        if (want.tx_overflowed) tx_ovf_seen = 1'b1;
        if (want.rx_overflowed) rx_ovf_seen = 1'b1;
      end
    end
    // held low through reset, random stalls afterwards
    rsp_ch.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
